>>> rtl/compass_planar_heading_unit_defines.svh
// Assertion macros for the compass planar heading unit.
// Used by the top level only; the including module must provide clk_i and rst_ni.
`ifndef COMPASS_PLANAR_HEADING_UNIT_DEFINES_SVH
`define COMPASS_PLANAR_HEADING_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPHU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("compass heading assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CPHU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("compass heading assertion failed");

`endif

>>> rtl/cphu_pkg.sv
// Shared types, constants and the arctangent table for the compass heading unit.
// No dependencies; every module of the block refers to it by scoped names.
package cphu_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned MaxStages       = 24;

  localparam int unsigned InW      = 13;
  localparam int unsigned OutW     = 15;
  localparam int unsigned VecW     = 24;
  localparam int unsigned AngW     = 29;
  localparam int unsigned HeadW    = 30;
  localparam int unsigned PreShift = 8;
  localparam int unsigned OutShift = 14;

  // Angles are degrees scaled by 2^20.
  localparam logic signed [HeadW-1:0] Deg90     = 30'sd94371840;
  localparam logic signed [HeadW-1:0] Deg270    = 30'sd283115520;
  localparam logic signed [HeadW-1:0] Deg360    = 30'sd377487360;
  localparam logic signed [HeadW-1:0] RoundBias = 30'sd8192;

  // Output codes in 1/64 degree.
  localparam logic [OutW-1:0] OutFull = 15'd23040;
  localparam logic [OutW-1:0] OutHalf = 15'd11520;

  // Flags that travel alongside the vector through the chain.
  typedef struct packed {
    logic yzero;
    logic yneg;
    logic xneg;
  } side_t;

  // Contents of one link of the chain.
  typedef struct packed {
    logic signed [VecW-1:0] vx;
    logic signed [VecW-1:0] vy;
    logic signed [AngW-1:0] z;
    side_t                  side;
  } vec_t;

  // atan(2^-idx) in degrees times 2^20, rounded to nearest.
  function automatic logic signed [AngW-1:0] atan_entry(input int unsigned idx);
    logic signed [AngW-1:0] a;
    unique case (idx)
      0:       a = 29'sd47185920;
      1:       a = 29'sd27855475;
      2:       a = 29'sd14718068;
      3:       a = 29'sd7471121;
      4:       a = 29'sd3750058;
      5:       a = 29'sd1876857;
      6:       a = 29'sd938658;
      7:       a = 29'sd469357;
      8:       a = 29'sd234682;
      9:       a = 29'sd117342;
      10:      a = 29'sd58671;
      11:      a = 29'sd29335;
      12:      a = 29'sd14668;
      13:      a = 29'sd7334;
      14:      a = 29'sd3667;
      15:      a = 29'sd1833;
      16:      a = 29'sd917;
      17:      a = 29'sd458;
      18:      a = 29'sd229;
      19:      a = 29'sd115;
      20:      a = 29'sd57;
      21:      a = 29'sd29;
      22:      a = 29'sd14;
      23:      a = 29'sd7;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/cphu_pre.sv
// Input stage of the heading chain: folds the sample into the right half-plane.
// Depends on cphu_pkg for widths and the link type.
module cphu_pre (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [cphu_pkg::InW-1:0]     x_axis_i,
  input  logic signed [cphu_pkg::InW-1:0]     y_axis_i,
  output logic                                valid_o,
  output cphu_pkg::vec_t                      vec_o
);

  logic                          yneg;
  logic signed [cphu_pkg::InW:0] x_ext;
  logic signed [cphu_pkg::InW:0] y_ext;
  logic signed [cphu_pkg::InW:0] num;
  logic signed [cphu_pkg::InW:0] den;
  cphu_pkg::vec_t                vec_d;
  cphu_pkg::vec_t                vec_q;
  logic                          valid_q;

  // Mirror through the origin when Y is negative, so the denominator is never negative.
  always_comb begin
    yneg  = y_axis_i[cphu_pkg::InW-1];
    x_ext = {x_axis_i[cphu_pkg::InW-1], x_axis_i};
    y_ext = {y_axis_i[cphu_pkg::InW-1], y_axis_i};
    num   = yneg ? -x_ext : x_ext;
    den   = yneg ? -y_ext : y_ext;
    vec_d.vx = {{(cphu_pkg::VecW-cphu_pkg::InW-1){den[cphu_pkg::InW]}}, den}
               << cphu_pkg::PreShift;
    vec_d.vy = {{(cphu_pkg::VecW-cphu_pkg::InW-1){num[cphu_pkg::InW]}}, num}
               << cphu_pkg::PreShift;
    vec_d.z  = '0;
    vec_d.side.yzero = (y_axis_i == '0);
    vec_d.side.yneg  = yneg;
    vec_d.side.xneg  = x_axis_i[cphu_pkg::InW-1];
  end

  // Valid bit is control state and is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

>>> rtl/cphu_cell.sv
// One CORDIC vectoring cell: a single micro-rotation with its own fixed shift.
// Depends on cphu_pkg for the link type and the arctangent table.
module cphu_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  cphu_pkg::vec_t vec_i,
  output logic           valid_o,
  output cphu_pkg::vec_t vec_o
);

  localparam logic signed [cphu_pkg::AngW-1:0] Angle = cphu_pkg::atan_entry(Idx);

  logic signed [cphu_pkg::VecW-1:0] vx;
  logic signed [cphu_pkg::VecW-1:0] vy;
  logic signed [cphu_pkg::VecW-1:0] dx;
  logic signed [cphu_pkg::VecW-1:0] dy;
  cphu_pkg::vec_t                   vec_d;
  cphu_pkg::vec_t                   vec_q;
  logic                             valid_q;

  // Rotate towards the X axis; the arithmetic shift rounds towards minus infinity.
  always_comb begin
    vx    = vec_i.vx;
    vy    = vec_i.vy;
    dx    = vy >>> Idx;
    dy    = vx >>> Idx;
    vec_d = vec_i;
    if (!vy[cphu_pkg::VecW-1]) begin
      vec_d.vx = vx + dx;
      vec_d.vy = vy - dy;
      vec_d.z  = vec_i.z + Angle;
    end else begin
      vec_d.vx = vx - dx;
      vec_d.vy = vy + dy;
      vec_d.z  = vec_i.z - Angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

>>> rtl/cphu_post.sv
// Output stage of the heading chain: quadrant offset, wrap and rounding.
// Depends on cphu_pkg for the angle constants and the link type.
module cphu_post (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  cphu_pkg::vec_t              vec_i,
  output logic                        valid_o,
  output logic [cphu_pkg::OutW-1:0]   heading_o
);

  logic signed [cphu_pkg::HeadW-1:0] z_ext;
  logic signed [cphu_pkg::HeadW-1:0] h_d;
  logic signed [cphu_pkg::HeadW-1:0] h_q;
  cphu_pkg::side_t                   side_q;
  logic                              valid_q;
  logic signed [cphu_pkg::HeadW-1:0] h_wrap;
  logic signed [cphu_pkg::HeadW-1:0] h_round;
  logic [cphu_pkg::OutW-1:0]         r;

  // Heading is 90 or 270 degrees less the arctangent, by the sign of Y.
  always_comb begin
    z_ext = {{(cphu_pkg::HeadW-cphu_pkg::AngW){vec_i.z[cphu_pkg::AngW-1]}}, vec_i.z};
    h_d   = (vec_i.side.yneg ? cphu_pkg::Deg270 : cphu_pkg::Deg90) - z_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_q    <= h_d;
      side_q <= vec_i.side;
    end
  end

  // Wrap into one turn, round to 1/64 degree and fold a rounded full turn to zero.
  always_comb begin
    priority if (h_q[cphu_pkg::HeadW-1]) begin
      h_wrap = h_q + cphu_pkg::Deg360;
    end else if (h_q >= cphu_pkg::Deg360) begin
      h_wrap = h_q - cphu_pkg::Deg360;
    end else begin
      h_wrap = h_q;
    end
    h_round = h_wrap + cphu_pkg::RoundBias;
    r       = h_round[cphu_pkg::OutShift+cphu_pkg::OutW-1:cphu_pkg::OutShift];
    if (side_q.yzero) begin
      heading_o = side_q.xneg ? cphu_pkg::OutHalf : '0;
    end else if (r >= cphu_pkg::OutFull) begin
      heading_o = r - cphu_pkg::OutFull;
    end else begin
      heading_o = r;
    end
  end

  assign valid_o = valid_q;

endmodule

>>> rtl/compass_planar_heading_unit.sv
// Top level of the compass planar heading unit: input stage, CORDIC cell chain,
// output stage and output skid buffer. Depends on cphu_pkg, cphu_pre, cphu_cell,
// cphu_post and the assertion macro header.
//
//   Channel   Direction  tdata bits (low first)           Per transfer
//   s_axis    in         [12:0] x_axis, [25:13] y_axis     one sample pair
//   m_axis    out        [14:0] heading_deg               one heading
//
// One sample pair is taken every cycle while the skid register is empty, and passes
// the input stage, one cell per CORDIC iteration, the output stage and the output
// register. Reset clears the valid bits of every stage and of the output buffer.
// When m_axis stalls, the output register holds its transfer and a skid register
// takes one more; only with the skid register full does the chain stop and
// s_axis_tready drop.
`include "compass_planar_heading_unit_defines.svh"

module compass_planar_heading_unit #(
  parameter int unsigned CORDIC_STAGES = cphu_pkg::CordicStagesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [12:0] x_axis, [25:13] y_axis, [31:26] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [14:0] heading_deg, [15] zero
);

  localparam int unsigned NumCells =
    (CORDIC_STAGES > cphu_pkg::MaxStages) ? cphu_pkg::MaxStages : CORDIC_STAGES;

  logic                      en;
  logic                      chain_valid [0:NumCells];
  cphu_pkg::vec_t            chain_vec   [0:NumCells];
  logic                      post_valid;
  logic [cphu_pkg::OutW-1:0] post_head;

  logic                      out_valid_d, out_valid_q;
  logic [cphu_pkg::OutW-1:0] out_head_d,  out_head_q;
  logic                      skid_valid_d, skid_valid_q;
  logic [cphu_pkg::OutW-1:0] skid_head_d,  skid_head_q;

  // The chain moves whenever the skid register has room.
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  cphu_pre u_pre (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .x_axis_i (s_axis_tdata[12:0]),
    .y_axis_i (s_axis_tdata[25:13]),
    .valid_o  (chain_valid[0]),
    .vec_o    (chain_vec[0])
  );

  // One cell per CORDIC iteration, each with its own shift and table angle.
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    cphu_cell #(
      .Idx (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[g]),
      .vec_i   (chain_vec[g]),
      .valid_o (chain_valid[g+1]),
      .vec_o   (chain_vec[g+1])
    );
  end

  cphu_post u_post (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (chain_valid[NumCells]),
    .vec_i     (chain_vec[NumCells]),
    .valid_o   (post_valid),
    .heading_o (post_head)
  );

  // Output register with a one-entry skid register behind it.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_head_d   = out_head_q;
    skid_valid_d = skid_valid_q;
    skid_head_d  = skid_head_q;
    if (skid_valid_q) begin
      if (m_axis_tready) begin
        out_head_d   = skid_head_q;
        skid_valid_d = 1'b0;
      end
    end else if (post_valid) begin
      if (!out_valid_q || m_axis_tready) begin
        out_valid_d = 1'b1;
        out_head_d  = post_head;
      end else begin
        skid_valid_d = 1'b1;
        skid_head_d  = post_head;
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_head_q  <= out_head_d;
    skid_head_q <= skid_head_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_head_q};

  // Checks on the output buffer.
  `CPHU_ASSERT_NOW(a_head_range, out_valid_q, out_head_q < cphu_pkg::OutFull)
  `CPHU_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)
  `CPHU_ASSERT_NEXT(a_stall_fills_skid,
    out_valid_q && !m_axis_tready && post_valid && !skid_valid_q, skid_valid_q)

endmodule
